// File: src/ecfp_pkg.sv
// Package: shared widths, register codes, frame types and the byte saturation helper.
`default_nettype none

package ecfp_pkg;

   // Encoder count width and gain fraction bits
   localparam int COUNT_WIDTH    = 16;
   localparam int GAIN_FRAC_BITS = 8;

   // Fixed field widths
   localparam int GAIN_W   = 12;
   localparam int OFFSET_W = 8;
   localparam int BYTE_W   = 8;
   localparam int FACTOR_W = 9;
   localparam int FACTOR_FRAC_BITS = 8;

   // Product widths: (count - bias) * gain, then times attenuation factor
   localparam int PROD_W = COUNT_WIDTH + 1 + GAIN_W;
   localparam int WIDE_W = PROD_W + FACTOR_W + 1;
   localparam int EXT_W  = WIDE_W - PROD_W;

   // Frame constants
   localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'hFF;
   localparam logic [BYTE_W-1:0] CHECK_ESCAPE = 8'hFE;
   localparam logic [BYTE_W-1:0] BYTE_MAX_OUT = 8'd254;
   localparam logic [BYTE_W-1:0] Y_BREAK_LOW  = 8'h80;
   localparam logic [BYTE_W-1:0] Y_BREAK_HIGH = 8'hE8;
   localparam int Y_BIAS = 20;

   // Attenuation factors, Q1.8
   localparam logic [FACTOR_W-1:0] K_ONE  = 9'd256;
   localparam logic [FACTOR_W-1:0] K_MID  = 9'd218;
   localparam logic [FACTOR_W-1:0] K_LOW  = 9'd154;
   localparam logic [FACTOR_W-1:0] K_HALF = 9'd128;

   // Register reset values
   localparam logic signed [GAIN_W-1:0] FINGER_GAIN_RST  = -12'sd333;
   localparam logic signed [GAIN_W-1:0] WRIST_X_GAIN_RST = 12'sd307;
   localparam logic signed [GAIN_W-1:0] WRIST_Y_GAIN_RST = 12'sd333;
   localparam logic signed [GAIN_W-1:0] WRIST_Z_GAIN_RST = -12'sd192;
   localparam logic [OFFSET_W-1:0] FINGER_OFFSET_RST  = 8'd0;
   localparam logic [OFFSET_W-1:0] WRIST_X_OFFSET_RST = 8'd128;
   localparam logic [OFFSET_W-1:0] WRIST_Y_OFFSET_RST = 8'd0;
   localparam logic [OFFSET_W-1:0] WRIST_Z_OFFSET_RST = 8'd128;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam int CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FINGER_GAIN    = 3'd0,
      CSR_WRIST_X_GAIN   = 3'd1,
      CSR_WRIST_Y_GAIN   = 3'd2,
      CSR_WRIST_Z_GAIN   = 3'd3,
      CSR_FINGER_OFFSET  = 3'd4,
      CSR_WRIST_X_OFFSET = 3'd5,
      CSR_WRIST_Y_OFFSET = 3'd6,
      CSR_WRIST_Z_OFFSET = 3'd7
   } csr_index_type;

   // Byte positions within a frame
   typedef enum logic [2:0] {
      POS_HEADER = 3'd0,
      POS_SWITCH = 3'd1,
      POS_FINGER = 3'd2,
      POS_WRIST_Y = 3'd3,
      POS_WRIST_X = 3'd4,
      POS_WRIST_Z = 3'd5,
      POS_CHECK  = 3'd6
   } pos_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] finger_gain;
      logic signed [GAIN_W-1:0] wrist_x_gain;
      logic signed [GAIN_W-1:0] wrist_y_gain;
      logic signed [GAIN_W-1:0] wrist_z_gain;
      logic [OFFSET_W-1:0]      finger_offset;
      logic [OFFSET_W-1:0]      wrist_x_offset;
      logic [OFFSET_W-1:0]      wrist_y_offset;
      logic [OFFSET_W-1:0]      wrist_z_offset;
   } cfg_type;

   // One finished frame, minus the constant header
   typedef struct packed {
      logic [BYTE_W-1:0] sw;
      logic [BYTE_W-1:0] finger;
      logic [BYTE_W-1:0] wrist_y;
      logic [BYTE_W-1:0] wrist_x;
      logic [BYTE_W-1:0] wrist_z;
      logic [BYTE_W-1:0] check;
   } frame_type;

   // Add offset and clamp to 0..254
   function automatic logic [BYTE_W-1:0] sat_byte(input logic signed [WIDE_W-1:0] q,
                                                  input logic [OFFSET_W-1:0] off);
      logic signed [WIDE_W:0] v;
      v = $signed({q[WIDE_W-1], q}) + $signed({{(WIDE_W + 1 - OFFSET_W){1'b0}}, off});
      if (v < 0) begin
         sat_byte = '0;
      end else if (v > $signed({{(WIDE_W + 1 - BYTE_W){1'b0}}, BYTE_MAX_OUT})) begin
         sat_byte = BYTE_MAX_OUT;
      end else begin
         sat_byte = v[BYTE_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: src/ecfp_chan_if.sv
// Channel interfaces: snapshot request channel and frame byte response channel.
`default_nettype none

interface ecfp_req_if import ecfp_pkg::*; ();
   logic valid;
   logic ready;
   logic helper_height_level;
   logic auto_level;
   logic lift_up_level;
   logic lift_down_level;
   logic curtain_open_level;
   logic curtain_close_level;
   logic lock_level;
   logic signed [COUNT_WIDTH-1:0] finger_count;
   logic signed [COUNT_WIDTH-1:0] wrist_x_count;
   logic signed [COUNT_WIDTH-1:0] wrist_y_count;
   logic signed [COUNT_WIDTH-1:0] wrist_z_count;

   modport source (output valid, helper_height_level, auto_level, lift_up_level,
                   lift_down_level, curtain_open_level, curtain_close_level, lock_level,
                   finger_count, wrist_x_count, wrist_y_count, wrist_z_count,
                   input ready);
   modport sink (input valid, helper_height_level, auto_level, lift_up_level,
                 lift_down_level, curtain_open_level, curtain_close_level, lock_level,
                 finger_count, wrist_x_count, wrist_y_count, wrist_z_count,
                 output ready);
endinterface

interface ecfp_rsp_if import ecfp_pkg::*; ();
   logic valid;
   logic ready;
   logic [BYTE_W-1:0] frame_byte;
   logic frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

`default_nettype wire

// File: src/encoder_command_frame_packer_core.sv
// Top level: encoder command frame packer.
// Each accepted snapshot (seven switch levels, four encoder counts) yields a
// seven-beat frame: 0xFF, switch byte, finger, wrist Y, wrist X, wrist Z and a
// checksum beat flagged by frame_end. A snapshot passes a three-stage scaling
// pipeline (gain multiply, floor/offset/clamp, attenuation multiply) into a
// two-entry frame queue; the serializer then sends one byte per beat from a
// registered output. Sustained rate is set by the serializer, which sends one
// byte per cycle unless the output stalls. Gains and offsets are written
// through the csr port while the block is idle: a rule for the user, which
// the block itself does not enforce.
`default_nettype none

module encoder_command_frame_packer_core import ecfp_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   ecfp_req_if.sink                    req_chan,
   ecfp_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]      csr_wr_data
);

   cfg_type   cfg;
   logic      q_ready, q_push, q_pop, q_valid;
   frame_type q_data, q_head;

   // Configuration registers
   ecfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Scaling pipeline
   ecfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   // Frame queue
   ecfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   // Byte serializer
   ecfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// File: src/ecfp_csr.sv
// Configuration registers: gains and offsets with their reset values.
`default_nettype none

module ecfp_csr import ecfp_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]      csr_wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FINGER_GAIN:    cfg_in.finger_gain    = $signed(csr_wr_data);
            CSR_WRIST_X_GAIN:   cfg_in.wrist_x_gain   = $signed(csr_wr_data);
            CSR_WRIST_Y_GAIN:   cfg_in.wrist_y_gain   = $signed(csr_wr_data);
            CSR_WRIST_Z_GAIN:   cfg_in.wrist_z_gain   = $signed(csr_wr_data);
            CSR_FINGER_OFFSET:  cfg_in.finger_offset  = csr_wr_data[OFFSET_W-1:0];
            CSR_WRIST_X_OFFSET: cfg_in.wrist_x_offset = csr_wr_data[OFFSET_W-1:0];
            CSR_WRIST_Y_OFFSET: cfg_in.wrist_y_offset = csr_wr_data[OFFSET_W-1:0];
            CSR_WRIST_Z_OFFSET: cfg_in.wrist_z_offset = csr_wr_data[OFFSET_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.finger_gain    <= FINGER_GAIN_RST;
         cfg_ff.wrist_x_gain   <= WRIST_X_GAIN_RST;
         cfg_ff.wrist_y_gain   <= WRIST_Y_GAIN_RST;
         cfg_ff.wrist_z_gain   <= WRIST_Z_GAIN_RST;
         cfg_ff.finger_offset  <= FINGER_OFFSET_RST;
         cfg_ff.wrist_x_offset <= WRIST_X_OFFSET_RST;
         cfg_ff.wrist_y_offset <= WRIST_Y_OFFSET_RST;
         cfg_ff.wrist_z_offset <= WRIST_Z_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: src/ecfp_front.sv
// Front end: three-stage scaling pipeline that turns a snapshot into a frame.
`default_nettype none

module ecfp_front import ecfp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   ecfp_req_if.sink     req_chan,
   input  wire cfg_type cfg,
   input  wire logic    q_ready,
   output logic         q_push,
   output frame_type    q_data
);

   // Stage valids
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic adv1, adv2, adv3;

   // Stage 1: raw products
   logic [BYTE_W-1:0]        sw1_ff, sw1_in;
   logic signed [PROD_W-1:0] fp1_ff, fp1_in, yp1_ff, yp1_in;
   logic signed [PROD_W-1:0] xp1_ff, xp1_in, zp1_ff, zp1_in;
   logic signed [COUNT_WIDTH:0] fc_ext, xc_ext, yc_bias, zc_ext;

   // Stage 2: finger and wrist Y bytes
   logic [BYTE_W-1:0]        sw2_ff, fb2_ff, fb2_in, yb2_ff, yb2_in;
   logic signed [PROD_W-1:0] xp2_ff, zp2_ff;
   logic signed [PROD_W-1:0] fs, ys;

   // Stage 3: attenuated wrist X and Z products
   logic [BYTE_W-1:0]        sw3_ff, fb3_ff, yb3_ff;
   logic signed [WIDE_W-1:0] xk3_ff, xk3_in, zk3_ff, zk3_in;
   logic [FACTOR_W-1:0]      kx, kz;

   // Output side
   logic [BYTE_W-1:0] xb, zb, sum;

   // Stage advance
   assign adv3 = !v3_ff || q_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_chan.ready = adv1;

   assign v1_in = adv1 ? req_chan.valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   // Stage 1 logic: switch byte and count-by-gain products
   always_comb begin
      sw1_in = {~req_chan.helper_height_level, ~req_chan.auto_level,
                ~req_chan.lift_up_level, ~req_chan.lift_down_level,
                ~req_chan.curtain_open_level, ~req_chan.curtain_close_level,
                req_chan.lock_level, 1'b0};
      fc_ext  = $signed({req_chan.finger_count[COUNT_WIDTH-1], req_chan.finger_count});
      xc_ext  = $signed({req_chan.wrist_x_count[COUNT_WIDTH-1], req_chan.wrist_x_count});
      zc_ext  = $signed({req_chan.wrist_z_count[COUNT_WIDTH-1], req_chan.wrist_z_count});
      yc_bias = $signed({req_chan.wrist_y_count[COUNT_WIDTH-1], req_chan.wrist_y_count})
                - $signed((COUNT_WIDTH + 1)'(Y_BIAS));
      fp1_in = fc_ext * cfg.finger_gain;
      yp1_in = yc_bias * cfg.wrist_y_gain;
      xp1_in = xc_ext * cfg.wrist_x_gain;
      zp1_in = zc_ext * cfg.wrist_z_gain;
   end

   // Stage 2 logic: floor, offset, clamp
   always_comb begin
      fs = fp1_ff >>> GAIN_FRAC_BITS;
      ys = yp1_ff >>> GAIN_FRAC_BITS;
      fb2_in = sat_byte({{EXT_W{fs[PROD_W-1]}}, fs}, cfg.finger_offset);
      yb2_in = sat_byte({{EXT_W{ys[PROD_W-1]}}, ys}, cfg.wrist_y_offset);
   end

   // Stage 3 logic: attenuation picked from the wrist Y byte
   always_comb begin
      if (yb2_ff > Y_BREAK_LOW) begin
         kx = (yb2_ff > Y_BREAK_HIGH) ? K_LOW : K_MID;
         kz = K_HALF;
      end else begin
         kx = K_ONE;
         kz = K_ONE;
      end
      xk3_in = xp2_ff * $signed({1'b0, kx});
      zk3_in = zp2_ff * $signed({1'b0, kz});
   end

   // Output: wrist X/Z bytes and checksum into the queue
   always_comb begin
      xb  = sat_byte(xk3_ff >>> (GAIN_FRAC_BITS + FACTOR_FRAC_BITS), cfg.wrist_x_offset);
      zb  = sat_byte(zk3_ff >>> (GAIN_FRAC_BITS + FACTOR_FRAC_BITS), cfg.wrist_z_offset);
      sum = sw3_ff + fb3_ff + yb3_ff + xb + zb;
      q_data.sw      = sw3_ff;
      q_data.finger  = fb3_ff;
      q_data.wrist_y = yb3_ff;
      q_data.wrist_x = xb;
      q_data.wrist_z = zb;
      q_data.check   = (sum == FRAME_HEADER) ? CHECK_ESCAPE : sum;
   end

   assign q_push = v3_ff && q_ready;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv1) begin
         sw1_ff <= sw1_in;
         fp1_ff <= fp1_in;
         yp1_ff <= yp1_in;
         xp1_ff <= xp1_in;
         zp1_ff <= zp1_in;
      end
      if (adv2) begin
         sw2_ff <= sw1_ff;
         fb2_ff <= fb2_in;
         yb2_ff <= yb2_in;
         xp2_ff <= xp1_ff;
         zp2_ff <= zp1_ff;
      end
      if (adv3) begin
         sw3_ff <= sw2_ff;
         fb3_ff <= fb2_ff;
         yb3_ff <= yb2_ff;
         xk3_ff <= xk3_in;
         zk3_ff <= zk3_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ecfp_queue.sv
// Frame queue: short FIFO between the scaling front end and the byte serializer.
`default_nettype none

module ecfp_queue import ecfp_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire frame_type push_data,
   output logic           push_ready,
   input  wire logic      pop,
   output logic           head_valid,
   output frame_type      head
);

   frame_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: src/ecfp_back.sv
// Back end: serializes the queued frame one byte per beat into the output register.
`default_nettype none

module ecfp_back import ecfp_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      head_valid,
   input  wire frame_type head,
   output logic           pop,
   ecfp_rsp_if.source     rsp_chan
);

   pos_type           pos_ff, pos_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              end_ff, end_in;
   logic              load;
   logic [BYTE_W-1:0] sel_byte;

   // Output register takes a new byte when empty or drained
   assign load = !valid_ff || rsp_chan.ready;

   // Byte select by frame position
   always_comb begin
      case (pos_ff)
         POS_HEADER:  sel_byte = FRAME_HEADER;
         POS_SWITCH:  sel_byte = head.sw;
         POS_FINGER:  sel_byte = head.finger;
         POS_WRIST_Y: sel_byte = head.wrist_y;
         POS_WRIST_X: sel_byte = head.wrist_x;
         POS_WRIST_Z: sel_byte = head.wrist_z;
         POS_CHECK:   sel_byte = head.check;
         default:     sel_byte = FRAME_HEADER;
      endcase
   end

   // Next-value logic
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         byte_in  = sel_byte;
         end_in   = (pos_ff == POS_CHECK);
         if (head_valid) begin
            if (pos_ff == POS_CHECK) begin
               pos_in = POS_HEADER;
               pop    = 1'b1;
            end else begin
               pos_in = pos_type'(pos_ff + 3'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HEADER;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.frame_byte = byte_ff;
   assign rsp_chan.frame_end  = end_ff;

endmodule

`default_nettype wire
